>>> design/tmtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmtp_pkg: shared definitions for the three mode traffic policer
// register map, mode and color codes, timestamp width
// ----------------------------------------------------------------------------
package tmtp_pkg;

  // width of the tick counter used for elapsed time
  localparam int TIME_BITS = 32;

  // refill sums saturate at this width; anything past it clamps at any cap
  localparam int SAT_BITS = 34;

  localparam int LEN_BITS  = 16;
  localparam int COST_BITS = LEN_BITS + 3;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_COMMIT_RATE = 3'd1;
  localparam logic [2:0] REG_PEAK_RATE   = 3'd2;
  localparam logic [2:0] REG_COMMIT_CAP  = 3'd3;
  localparam logic [2:0] REG_PEAK_CAP    = 3'd4;

  // policing modes
  localparam logic [1:0] MODE_BUCKET      = 2'd0;
  localparam logic [1:0] MODE_SINGLE_RATE = 2'd1;
  localparam logic [1:0] MODE_TWO_RATE    = 2'd2;

  typedef enum logic [1:0] {
    COLOR_NONE   = 2'd0,
    COLOR_RED    = 2'd1,
    COLOR_YELLOW = 2'd2,
    COLOR_GREEN  = 2'd3
  } color_t;

endpackage : tmtp_pkg
`default_nettype wire

>>> design/three_mode_traffic_policer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_mode_traffic_policer: token bucket, srTCM and trTCM packet policer
// per packet refill, color decision and debit in a single registered pass
// ----------------------------------------------------------------------------
// Each packet transfer on the slave stream carries a tick timestamp and a
// length in bytes; one result transfer per packet comes back on the master
// stream with a matched flag and a color. A packet is registered on input,
// judged by one pass of refill (elapsed ticks times rate, saturating add),
// clamp, compare and debit, and the result lands in an output register at the
// same edge that updates the bucket state. The result passes through the input
// register and then the output register, and a new packet is taken every cycle
// while the master side keeps up: the credit feedback loop closes within that
// one pass, so the next packet sees the debited buckets. Configuration goes
// through the APB port; the user must write it only while the block is idle,
// which the block itself does not enforce. Any write clears the primed flag, so
// the next packet refills both buckets to their caps and takes its own timestamp
// as the reference time. Mode code 3 gives matched 0, color none and leaves all
// state alone.
// ----------------------------------------------------------------------------
module three_mode_traffic_policer
  import tmtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // slave stream: packets in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] timestamp, [47:32] packet_length

  // master stream: results out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] matched, [2:1] color, [7:3] zero

  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [SAT_BITS-1:0] SAT_MAX = {SAT_BITS{1'b1}};

  // configuration registers
  logic [1:0]  mode;
  logic [31:0] commit_rate;
  logic [31:0] peak_rate;
  logic [31:0] commit_cap;
  logic [31:0] peak_cap;

  // bucket state
  logic [31:0]          commit_credit;
  logic [31:0]          peak_credit;
  logic [TIME_BITS-1:0] last_time;
  logic                 primed;

  // input register
  logic                in_valid;
  logic [31:0]         in_time;
  logic [LEN_BITS-1:0] in_len;

  // output register
  logic   out_matched;
  color_t out_color;

  logic cfg_write;
  logic advance;

  // pass logic
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] elapsed;
  logic [31:0]          cc_base;
  logic [31:0]          pc_base;
  logic [COST_BITS-1:0] cost;
  logic [31:0]          cost_w;
  logic [SAT_BITS-1:0]  total;
  logic [SAT_BITS-1:0]  ptotal;
  logic [31:0]          cc_clamp;
  logic [31:0]          pc_clamp;
  logic [SAT_BITS-1:0]  extra;
  logic [SAT_BITS:0]    spill_sum;
  logic [31:0]          pc_spill;

  logic [31:0]          commit_credit_next;
  logic [31:0]          peak_credit_next;
  logic                 primed_next;
  logic                 matched_next;
  color_t               color_next;

  // credit + elapsed * rate, saturated to SAT_BITS
  function automatic logic [SAT_BITS-1:0] refill(
    input logic [31:0]          credit,
    input logic [TIME_BITS-1:0] el,
    input logic [31:0]          rate
  );
    logic [TIME_BITS+31:0] prod;
    logic [TIME_BITS+32:0] sum;
    prod = (TIME_BITS+32)'(el) * (TIME_BITS+32)'(rate);
    sum  = {1'b0, prod} + (TIME_BITS+33)'(credit);
    if (sum > (TIME_BITS+33)'(SAT_MAX)) begin
      return SAT_MAX;
    end
    return sum[SAT_BITS-1:0];
  endfunction

  // clamp a saturated sum at a 32 bit cap
  function automatic logic [31:0] clamp(
    input logic [SAT_BITS-1:0] value,
    input logic [31:0]         cap
  );
    if (value > SAT_BITS'(cap)) begin
      return cap;
    end
    return value[31:0];
  endfunction

  // handshakes
  assign cfg_write = psel && penable && pwrite && pready;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign pready    = 1'b1;

  assign m_tdata = {5'd0, out_color, out_matched};

  // register read
  always_comb begin
    case (paddr[4:2])
      REG_MODE:        prdata = {30'd0, mode};
      REG_COMMIT_RATE: prdata = commit_rate;
      REG_PEAK_RATE:   prdata = peak_rate;
      REG_COMMIT_CAP:  prdata = commit_cap;
      REG_PEAK_CAP:    prdata = peak_cap;
      default:         prdata = 32'd0;
    endcase
  end

  // single pass: refill, clamp, judge, debit
  always_comb begin
    now      = TIME_BITS'(in_time);
    // first packet while unprimed starts from full buckets with no elapsed time
    cc_base  = primed ? commit_credit : commit_cap;
    pc_base  = primed ? peak_credit : peak_cap;
    elapsed  = primed ? (now - last_time) : '0;
    cost     = {in_len, 3'b000};
    cost_w   = 32'(cost);

    total    = refill(cc_base, elapsed, commit_rate);
    ptotal   = refill(pc_base, elapsed, peak_rate);
    cc_clamp = clamp(total, commit_cap);
    pc_clamp = clamp(ptotal, peak_cap);

    // srTCM spill of committed overflow into the excess bucket
    extra     = (total > SAT_BITS'(commit_cap)) ? (total - SAT_BITS'(commit_cap)) : '0;
    spill_sum = {1'b0, extra} + (SAT_BITS+1)'(pc_base);
    if (pc_base < peak_cap && extra != '0) begin
      pc_spill = (spill_sum > (SAT_BITS+1)'(peak_cap)) ? peak_cap : spill_sum[31:0];
    end else begin
      pc_spill = pc_base;
    end

    commit_credit_next = commit_credit;
    peak_credit_next   = peak_credit;
    primed_next        = primed;
    matched_next       = 1'b1;
    color_next         = COLOR_NONE;

    case (mode)
      MODE_BUCKET: begin
        primed_next      = 1'b1;
        peak_credit_next = pc_base;
        if (cc_clamp >= cost_w) begin
          commit_credit_next = cc_clamp - cost_w;
        end else begin
          commit_credit_next = cc_clamp;
          matched_next       = 1'b0;
        end
      end
      MODE_SINGLE_RATE: begin
        primed_next        = 1'b1;
        commit_credit_next = cc_clamp;
        peak_credit_next   = pc_spill;
        if (cc_clamp >= cost_w) begin
          color_next         = COLOR_GREEN;
          commit_credit_next = cc_clamp - cost_w;
        end else if (pc_spill >= cost_w) begin
          color_next       = COLOR_YELLOW;
          peak_credit_next = pc_spill - cost_w;
        end else begin
          color_next = COLOR_RED;
        end
      end
      MODE_TWO_RATE: begin
        primed_next        = 1'b1;
        commit_credit_next = cc_clamp;
        peak_credit_next   = pc_clamp;
        if (pc_clamp < cost_w) begin
          color_next = COLOR_RED;
        end else if (cc_clamp < cost_w) begin
          color_next       = COLOR_YELLOW;
          peak_credit_next = pc_clamp - cost_w;
        end else begin
          color_next         = COLOR_GREEN;
          peak_credit_next   = pc_clamp - cost_w;
          commit_credit_next = cc_clamp - cost_w;
        end
      end
      default: begin
        // unused mode code: no state change
        matched_next = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_BUCKET;
      commit_rate <= 32'd0;
      peak_rate   <= 32'd0;
      commit_cap  <= 32'd0;
      peak_cap    <= 32'd0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_MODE:        mode        <= pwdata[1:0];
        REG_COMMIT_RATE: commit_rate <= pwdata;
        REG_PEAK_RATE:   peak_rate   <= pwdata;
        REG_COMMIT_CAP:  commit_cap  <= pwdata;
        REG_PEAK_CAP:    peak_cap    <= pwdata;
        default: ;
      endcase
    end
  end

  // bucket state, updated as each packet leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      commit_credit <= 32'd0;
      peak_credit   <= 32'd0;
      last_time     <= '0;
      primed        <= 1'b0;
    end else if (cfg_write) begin
      // any write, even to an unused address, forces a fresh fill
      primed <= 1'b0;
    end else if (advance) begin
      commit_credit <= commit_credit_next;
      peak_credit   <= peak_credit_next;
      primed        <= primed_next;
      if (primed_next) begin
        last_time <= now;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_time <= s_tdata[31:0];
      in_len  <= s_tdata[47:32];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_matched <= matched_next;
      out_color   <= color_next;
    end
  end

`ifndef SYNTHESIS
  // a configuration write always leaves the block unprimed
  a_cfg_clears_primed: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !primed)
    else $error("primed still set after a configuration write");

  // once primed, the committed bucket never holds more than its cap
  a_commit_within_cap: assert property (@(posedge clk) disable iff (rst)
    primed |-> commit_credit <= commit_cap)
    else $error("committed credit above cap");

  // once primed, the peak bucket never holds more than its cap
  a_peak_within_cap: assert property (@(posedge clk) disable iff (rst)
    primed |-> peak_credit <= peak_cap)
    else $error("peak credit above cap");

  // every packet that leaves the input register shows up as a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result missing after packet judged");
`endif

endmodule : three_mode_traffic_policer
`default_nettype wire

>>> verif/three_mode_traffic_policer_tb.sv
// ----------------------------------------------------------------------------
// three_mode_traffic_policer_tb: self-checking bench for the packet policer
// directed table of corner cases, then randomized traffic over many register
// settings, every result checked in order against a built-in bucket model or,
// for directed packets, against a verdict typed in by hand
module three_mode_traffic_policer_tb;
  import tmtp_pkg::*;

  // mode code the block must treat as a no-op
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  // register slots past the map, written to check they are ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // idle cycles after the last result before touching registers
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 24;
  localparam int PKTS_PER_PHASE = 80;

  // bucket sizes that show up in typical policer setups
  localparam logic [31:0] BURST_SMALL = 32'h0010_0000;
  localparam logic [31:0] BURST_MID   = 32'h0020_0000;
  localparam logic [31:0] BURST_BIG   = 32'h0030_0000;

  typedef logic [64:0] wide_t;

  typedef struct packed {
    logic   matched;
    color_t color;
  } verdict_t;

  // one directed step: a register write or a packet, optionally with its
  // verdict typed in by hand
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [31:0] word;
    logic [15:0] len;
    logic        given;
    verdict_t    v;
  } step_t;

  typedef struct packed {
    logic     given;
    verdict_t v;
  } known_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [31:0] timestamp, [47:32] packet_length
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] matched, [2:1] color, [7:3] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  three_mode_traffic_policer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // bucket model: registers and credit state as seen by the bench
  // ---------------------------------------------------------------------------
  logic [1:0]  pol_mode;
  logic [31:0] pol_commit_rate;
  logic [31:0] pol_peak_rate;
  logic [31:0] pol_commit_cap;
  logic [31:0] pol_peak_cap;
  logic [31:0] commit_bits;
  logic [31:0] peak_bits;
  logic [31:0] last_tick;
  logic        buckets_primed;

  verdict_t verdict_q[$];   // verdicts still owed by the block
  known_t   known_q[$];     // hand-typed verdicts for directed packets
  int       errors = 0;
  int       gap_pct = 0;
  int       stall_pct = 0;

  // judge one packet and update the model buckets
  function automatic verdict_t police_packet(input logic [31:0] ts, input logic [15:0] len);
    logic [31:0] elapsed;
    logic [31:0] cost;
    wide_t       cfill;
    wide_t       pfill;
    wide_t       spill;
    verdict_t    v;
    v.matched = 1'b1;
    v.color   = COLOR_NONE;
    cost      = {13'd0, len, 3'b000};
    if (pol_mode == MODE_UNUSED) begin
      // no state change, stays unprimed
      v.matched = 1'b0;
      return v;
    end
    if (!buckets_primed) begin
      commit_bits    = pol_commit_cap;
      peak_bits      = pol_peak_cap;
      last_tick      = ts;
      buckets_primed = 1'b1;
    end
    elapsed   = ts - last_tick;   // wraps modulo 2^32
    last_tick = ts;
    // 65 bits hold the largest refill without saturation
    cfill = wide_t'(commit_bits) + wide_t'(elapsed) * wide_t'(pol_commit_rate);
    case (pol_mode)
      MODE_BUCKET: begin
        commit_bits = (cfill > wide_t'(pol_commit_cap)) ? pol_commit_cap : cfill[31:0];
        if (commit_bits >= cost) commit_bits = commit_bits - cost;
        else v.matched = 1'b0;
      end
      MODE_SINGLE_RATE: begin
        // committed overflow spills into the excess bucket
        spill = '0;
        if (cfill > wide_t'(pol_commit_cap)) begin
          spill = cfill - wide_t'(pol_commit_cap);
          cfill = wide_t'(pol_commit_cap);
        end
        commit_bits = cfill[31:0];
        if (peak_bits < pol_peak_cap && spill != '0) begin
          pfill     = spill + wide_t'(peak_bits);
          peak_bits = (pfill > wide_t'(pol_peak_cap)) ? pol_peak_cap : pfill[31:0];
        end
        if (commit_bits >= cost) begin
          v.color     = COLOR_GREEN;
          commit_bits = commit_bits - cost;
        end else if (peak_bits >= cost) begin
          v.color   = COLOR_YELLOW;
          peak_bits = peak_bits - cost;
        end else begin
          v.color = COLOR_RED;
        end
      end
      default: begin
        // two rate: independent refills, peak checked first
        pfill = wide_t'(peak_bits) + wide_t'(elapsed) * wide_t'(pol_peak_rate);
        commit_bits = (cfill > wide_t'(pol_commit_cap)) ? pol_commit_cap : cfill[31:0];
        peak_bits   = (pfill > wide_t'(pol_peak_cap)) ? pol_peak_cap : pfill[31:0];
        if (peak_bits < cost) begin
          v.color = COLOR_RED;
        end else if (commit_bits < cost) begin
          v.color   = COLOR_YELLOW;
          peak_bits = peak_bits - cost;
        end else begin
          v.color     = COLOR_GREEN;
          peak_bits   = peak_bits - cost;
          commit_bits = commit_bits - cost;
        end
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: everything sampled at the rising edge, before the edge's updates
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    verdict_t got;
    verdict_t want;
    known_t   k;
    if (rst) begin
      pol_mode        = MODE_BUCKET;
      pol_commit_rate = '0;
      pol_peak_rate   = '0;
      pol_commit_cap  = '0;
      pol_peak_cap    = '0;
      commit_bits     = '0;
      peak_bits       = '0;
      last_tick       = '0;
      buckets_primed  = 1'b0;
    end else begin
      // result transfer against the oldest owed verdict
      if (m_tvalid && m_tready) begin
        got.matched = m_tdata[0];
        got.color   = color_t'(m_tdata[2:1]);
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual matched %0b color %0d",
                   $time, got.matched, got.color);
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched) begin
            errors++;
            $display("%0t: matched mismatch, expected %0b, actual %0b",
                     $time, want.matched, got.matched);
          end
          if (got.color !== want.color) begin
            errors++;
            $display("%0t: color mismatch, expected %0d, actual %0d",
                     $time, want.color, got.color);
          end
        end
      end
      // register write, any slot clears the primed flag
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MODE:        pol_mode        = pwdata[1:0];
          REG_COMMIT_RATE: pol_commit_rate = pwdata;
          REG_PEAK_RATE:   pol_peak_rate   = pwdata;
          REG_COMMIT_CAP:  pol_commit_cap  = pwdata;
          REG_PEAK_CAP:    pol_peak_cap    = pwdata;
          default: ;
        endcase
        buckets_primed = 1'b0;
      end
      // packet transfer: model always runs, a typed verdict wins if present
      if (s_tvalid && s_tready) begin
        want = police_packet(s_tdata[31:0], s_tdata[47:32]);
        if (known_q.size() != 0) begin
          k = known_q.pop_front();
          if (k.given) want = k.v;
        end
        verdict_q.push_back(want);
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_pkt(input logic [31:0] ts, input logic [15:0] len);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {len, ts};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait for every owed result, then let the pipe settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic step_t cfg_row(input logic [2:0] idx, input logic [31:0] value);
    step_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.word   = value;
    return s;
  endfunction

  function automatic step_t pkt_row(input logic [31:0] ts, input logic [15:0] len);
    step_t s;
    s      = '0;
    s.word = ts;
    s.len  = len;
    return s;
  endfunction

  function automatic step_t known_row(input logic [31:0] ts, input logic [15:0] len,
                                      input logic matched, input color_t color);
    step_t s;
    s           = pkt_row(ts, len);
    s.given     = 1'b1;
    s.v.matched = matched;
    s.v.color   = color;
    return s;
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(4000);
    endcase
  endfunction

  function automatic logic [31:0] pick_cap();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      3:       return BURST_SMALL;
      4:       return BURST_MID;
      5:       return BURST_BIG;
      default: return $urandom_range(200000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_t       plan[$];
    step_t       row;
    known_t      k;
    logic [31:0] ts_now;
    logic [31:0] word;
    logic [15:0] len;
    logic [1:0]  mode_pick;
    int          r;

    // all registers zero after reset: zero cost passes, anything else fails
    plan.push_back(known_row(32'd0, 16'd0, 1'b1, COLOR_NONE));
    plan.push_back(known_row(32'd5, 16'd1, 1'b0, COLOR_NONE));
    // unused mode: no match, no color, no state change
    plan.push_back(cfg_row(REG_MODE, {30'd0, MODE_UNUSED}));
    plan.push_back(known_row(32'd6, 16'hFFFF, 1'b0, COLOR_NONE));
    plan.push_back(known_row(32'hFFFF_FFFF, 16'd0, 1'b0, COLOR_NONE));
    // plain bucket: first packet fills to the cap and drains it exactly
    plan.push_back(cfg_row(REG_MODE, {30'd0, MODE_BUCKET}));
    plan.push_back(cfg_row(REG_COMMIT_RATE, 32'd8));
    plan.push_back(cfg_row(REG_COMMIT_CAP, 32'd8000));
    plan.push_back(known_row(32'd100, 16'd1000, 1'b1, COLOR_NONE));
    plan.push_back(known_row(32'd100, 16'd1, 1'b0, COLOR_NONE));
    plan.push_back(known_row(32'd101, 16'd1, 1'b1, COLOR_NONE));
    // huge elapsed clamps at the cap, then the timestamp wraps
    plan.push_back(pkt_row(32'hFFFF_FFFF, 16'hFFFF));
    plan.push_back(pkt_row(32'd3, 16'd500));
    // saturating refill at full rate and full cap
    plan.push_back(cfg_row(REG_COMMIT_RATE, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_COMMIT_CAP, 32'hFFFF_FFFF));
    plan.push_back(known_row(32'd0, 16'hFFFF, 1'b1, COLOR_NONE));
    plan.push_back(pkt_row(32'hFFFF_FFFF, 16'hFFFF));
    // single rate: green, then yellow twice from excess, then red
    plan.push_back(cfg_row(REG_MODE, {30'd0, MODE_SINGLE_RATE}));
    plan.push_back(cfg_row(REG_COMMIT_RATE, 32'd1));
    plan.push_back(cfg_row(REG_COMMIT_CAP, 32'd8000));
    plan.push_back(cfg_row(REG_PEAK_CAP, 32'd16000));
    plan.push_back(known_row(32'd0, 16'd1000, 1'b1, COLOR_GREEN));
    plan.push_back(known_row(32'd0, 16'd1000, 1'b1, COLOR_YELLOW));
    plan.push_back(known_row(32'd0, 16'd1000, 1'b1, COLOR_YELLOW));
    plan.push_back(known_row(32'd0, 16'd1, 1'b1, COLOR_RED));
    // long idle spills committed overflow into the excess bucket
    plan.push_back(pkt_row(32'd20000, 16'd1));
    // two rate: green debits both, yellow debits peak, red when peak empty
    plan.push_back(cfg_row(REG_MODE, {30'd0, MODE_TWO_RATE}));
    plan.push_back(cfg_row(REG_PEAK_RATE, 32'd2));
    plan.push_back(known_row(32'd0, 16'd1000, 1'b1, COLOR_GREEN));
    plan.push_back(known_row(32'd0, 16'd1000, 1'b1, COLOR_YELLOW));
    plan.push_back(known_row(32'd0, 16'd1, 1'b1, COLOR_RED));
    plan.push_back(pkt_row(32'd100, 16'd10));
    // write past the map: ignored but the buckets refill again
    plan.push_back(cfg_row(REG_SPARE_LO, BURST_BIG));
    plan.push_back(pkt_row(32'd7, 16'd200));
    plan.push_back(cfg_row(REG_SPARE_HI, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_PEAK_RATE, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_PEAK_CAP, 32'hFFFF_FFFF));
    plan.push_back(pkt_row(32'd0, 16'hFFFF));
    plan.push_back(pkt_row(32'hFFFF_0000, 16'd1234));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (plan[n]) begin
      row = plan[n];
      if (row.is_cfg) begin
        drain_results();
        write_reg(row.idx, row.word);
      end else begin
        k.given = row.given;
        k.v     = row.v;
        known_q.push_back(k);
        send_pkt(row.word, row.len);
      end
    end

    // randomized traffic, one register setting per phase
    ts_now = $urandom();
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 51; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 51; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      r = $urandom_range(9);
      mode_pick = (r < 3) ? MODE_BUCKET : (r < 6) ? MODE_SINGLE_RATE :
                  (r < 9) ? MODE_TWO_RATE : MODE_UNUSED;
      // first two phases pin the register extremes
      if (p == 0) mode_pick = MODE_TWO_RATE;
      if (p == 1) mode_pick = MODE_SINGLE_RATE;
      word = $urandom();
      write_reg(REG_MODE, {word[31:2], mode_pick});
      write_reg(REG_COMMIT_RATE, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 : pick_rate());
      write_reg(REG_PEAK_RATE, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 : pick_rate());
      write_reg(REG_COMMIT_CAP, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 : pick_cap());
      write_reg(REG_PEAK_CAP, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'd0 : pick_cap());
      if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 5)), $urandom());

      for (int i = 0; i < PKTS_PER_PHASE; i++) begin
        // sender holds off until the block has caught up
        if (p % 3 == 1 && i == PKTS_PER_PHASE / 2) drain_results();
        r = $urandom_range(99);
        if (r < 70)      ts_now = ts_now + $urandom_range(20);
        else if (r < 90) ts_now = ts_now + $urandom_range(2000);
        else if (r < 97) ts_now = ts_now;
        else             ts_now = $urandom();
        r = $urandom_range(99);
        if (r < 80)      len = 16'($urandom_range(1500, 40));
        else if (r < 90) len = 16'($urandom_range(65535));
        else if (r < 94) len = 16'($urandom_range(39));
        else if (r < 97) len = 16'd0;
        else             len = 16'hFFFF;
        send_pkt(ts_now, len);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/tmtp_pkg.sv
design/three_mode_traffic_policer.sv
verif/three_mode_traffic_policer_tb.sv
